>>> sv/aavr_pkg.sv
`default_nettype none
package aavr_pkg;

  localparam int VEC_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int AXIS_WIDTH = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int CW = 34;
  localparam int TERM_W = 31;
  localparam int IN_W = ((3 * VEC_WIDTH + 3 * AXIS_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((3 * VEC_WIDTH + 7) / 8) * 8;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] ONE_Q30 = 34'sh040000000;
  localparam logic signed [35:0] TERM_LIMIT = 36'sh020000000;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] z;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [AXIS_WIDTH-1:0] z;
    logic signed [AXIS_WIDTH-1:0] y;
    logic signed [AXIS_WIDTH-1:0] x;
  } axis_t;

  typedef struct packed {
    vec_t vec;
    axis_t axis;
  } item_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  typedef logic [TERM_W-1:0] term_t;
  typedef term_t [8:0] mat_t;

  function automatic logic signed [CW-1:0] atan_turns(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sh020000000;
      1: r = 34'sh012E4051E;
      2: r = 34'sh009FB385B;
      3: r = 34'sh0051111D4;
      4: r = 34'sh0028B0D43;
      5: r = 34'sh00145D7E1;
      6: r = 34'sh000A2F61E;
      7: r = 34'sh000517C55;
      8: r = 34'sh00028BE53;
      9: r = 34'sh000145F2F;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2FA;
      15: r = 34'sh00000517D;
      16: r = 34'sh0000028BE;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A30;
      19: r = 34'sh000000518;
      20: r = 34'sh00000028C;
      21: r = 34'sh000000146;
      22: r = 34'sh0000000A3;
      23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/aavr_cordic.sv
`default_nettype none
module aavr_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire aavr_pkg::item_t in_item,
  input  wire logic [aavr_pkg::ANGLE_WIDTH-1:0] in_angle,
  output logic out_valid,
  output aavr_pkg::item_t out_item,
  output aavr_pkg::sc_t out_sc
);

  localparam int N = aavr_pkg::CORDIC_N;
  localparam int CW = aavr_pkg::CW;

  logic signed [CW-1:0] xr [0:N];
  logic signed [CW-1:0] yr [0:N];
  logic signed [CW-1:0] zr [0:N];
  logic negr [0:N];
  logic vr [0:N];
  aavr_pkg::item_t itr [0:N];

  logic [31:0] ph;
  logic neg;
  logic [31:0] phf;
  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;

  assign ph = {in_angle, {(32 - aavr_pkg::ANGLE_WIDTH){1'b0}}};
  assign neg = ph[31] ^ ph[30];
  assign phf = {ph[31] ^ neg, ph[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= aavr_pkg::CORDIC_GAIN;
      yr[0] <= '0;
      zr[0] <= CW'($signed(phf));
      negr[0] <= neg;
      itr[0] <= in_item;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i+1] <= 1'b0;
      end else if (en) begin
        vr[i+1] <= vr[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zr[i][CW-1]) begin
          xr[i+1] <= xr[i] - (yr[i] >>> i);
          yr[i+1] <= yr[i] + (xr[i] >>> i);
          zr[i+1] <= zr[i] - aavr_pkg::atan_turns(i);
        end else begin
          xr[i+1] <= xr[i] + (yr[i] >>> i);
          yr[i+1] <= yr[i] - (xr[i] >>> i);
          zr[i+1] <= zr[i] + aavr_pkg::atan_turns(i);
        end
        negr[i+1] <= negr[i];
        itr[i+1] <= itr[i];
      end
    end
  end

  assign nx = negr[N] ? -xr[N] : xr[N];
  assign ny = negr[N] ? -yr[N] : yr[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vr[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (nx > aavr_pkg::ONE_Q30) begin
        out_sc.c <= 32'(aavr_pkg::ONE_Q30);
      end else if (nx < -aavr_pkg::ONE_Q30) begin
        out_sc.c <= 32'(-aavr_pkg::ONE_Q30);
      end else begin
        out_sc.c <= 32'(nx);
      end
      if (ny > aavr_pkg::ONE_Q30) begin
        out_sc.s <= 32'(aavr_pkg::ONE_Q30);
      end else if (ny < -aavr_pkg::ONE_Q30) begin
        out_sc.s <= 32'(-aavr_pkg::ONE_Q30);
      end else begin
        out_sc.s <= 32'(ny);
      end
      out_item <= itr[N];
    end
  end

endmodule
`default_nettype wire

>>> sv/aavr_terms.sv
`default_nettype none
module aavr_terms (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire aavr_pkg::item_t in_item,
  input  wire aavr_pkg::sc_t in_sc,
  output logic out_valid,
  output aavr_pkg::vec_t out_vec,
  output aavr_pkg::mat_t out_mat
);

  function automatic logic signed [34:0] mul_t(input logic signed [31:0] p,
                                               input logic signed [33:0] t);
    logic signed [65:0] r;
    r = p * t;
    return 35'(r >>> 31);
  endfunction

  function automatic logic signed [31:0] mul_w(input logic signed [15:0] a,
                                               input logic signed [31:0] s);
    logic signed [47:0] r;
    r = a * s;
    return 32'(r >>> 17);
  endfunction

  function automatic aavr_pkg::term_t mk_term(input logic signed [34:0] q,
                                              input logic signed [31:0] e);
    logic signed [35:0] r;
    r = 36'(q) + 36'(e);
    if (r > aavr_pkg::TERM_LIMIT) begin
      r = aavr_pkg::TERM_LIMIT;
    end else if (r < -aavr_pkg::TERM_LIMIT) begin
      r = -aavr_pkg::TERM_LIMIT;
    end
    return aavr_pkg::TERM_W'(r);
  endfunction

  logic va, vb;
  aavr_pkg::vec_t veca, vecb;
  logic signed [33:0] ta;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [31:0] c27a, c27b;
  logic signed [31:0] wxa, wya, wza, wxb, wyb, wzb;
  logic signed [34:0] qxx, qyy, qzz, qxy, qxz, qyz;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      veca <= in_item.vec;
      ta <= aavr_pkg::ONE_Q30 - 34'(in_sc.c);
      c27a <= in_sc.c >>> 3;
      pxx <= in_item.axis.x * in_item.axis.x;
      pyy <= in_item.axis.y * in_item.axis.y;
      pzz <= in_item.axis.z * in_item.axis.z;
      pxy <= in_item.axis.x * in_item.axis.y;
      pxz <= in_item.axis.x * in_item.axis.z;
      pyz <= in_item.axis.y * in_item.axis.z;
      wxa <= mul_w(in_item.axis.x, in_sc.s);
      wya <= mul_w(in_item.axis.y, in_sc.s);
      wza <= mul_w(in_item.axis.z, in_sc.s);

      vecb <= veca;
      c27b <= c27a;
      wxb <= wxa;
      wyb <= wya;
      wzb <= wza;
      qxx <= mul_t(pxx, ta);
      qyy <= mul_t(pyy, ta);
      qzz <= mul_t(pzz, ta);
      qxy <= mul_t(pxy, ta);
      qxz <= mul_t(pxz, ta);
      qyz <= mul_t(pyz, ta);

      out_vec <= vecb;
      out_mat[0] <= mk_term(qxx, c27b);
      out_mat[1] <= mk_term(qxy, -wzb);
      out_mat[2] <= mk_term(qxz, wyb);
      out_mat[3] <= mk_term(qxy, wzb);
      out_mat[4] <= mk_term(qyy, c27b);
      out_mat[5] <= mk_term(qyz, -wxb);
      out_mat[6] <= mk_term(qxz, -wyb);
      out_mat[7] <= mk_term(qyz, wxb);
      out_mat[8] <= mk_term(qzz, c27b);
    end
  end

endmodule
`default_nettype wire

>>> sv/aavr_apply.sv
`default_nettype none
module aavr_apply (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire aavr_pkg::vec_t in_vec,
  input  wire aavr_pkg::mat_t in_mat,
  output logic out_valid,
  output aavr_pkg::vec_t out_vec
);

  localparam int VW = aavr_pkg::VEC_WIDTH;
  localparam int SW = aavr_pkg::TERM_W + VW + 2;

  logic vd, ve;
  logic signed [SW-1:0] phi [0:8];
  logic signed [SW-1:0] plo [0:8];
  logic signed [SW-1:0] shi [0:2];
  logic signed [SW-1:0] slo [0:2];
  logic signed [SW-1:0] r [0:2];
  logic signed [VW-1:0] sat [0:2];
  logic signed [VW-1:0] vin [0:2];

  localparam logic signed [SW-1:0] VMAX = SW'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  assign vin[0] = in_vec.x;
  assign vin[1] = in_vec.y;
  assign vin[2] = in_vec.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vd <= in_valid;
      ve <= vd;
      out_valid <= ve;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          phi[k*3+j] <= $signed(in_mat[k*3+j]) * (vin[j] >>> 16);
          plo[k*3+j] <= $signed(in_mat[k*3+j]) * $signed({1'b0, vin[j][15:0]});
        end
      end
    end

    assign r[k] = (shi[k] + (slo[k] >>> 16)) >>> 11;
    assign sat[k] = (r[k] > VMAX) ? VMAX[VW-1:0] :
                    (r[k] < VMIN) ? VMIN[VW-1:0] : r[k][VW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        shi[k] <= phi[k*3] + phi[k*3+1] + phi[k*3+2];
        slo[k] <= plo[k*3] + plo[k*3+1] + plo[k*3+2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec.x <= sat[0];
      out_vec.y <= sat[1];
      out_vec.z <= sat[2];
    end
  end

endmodule
`default_nettype wire

>>> sv/axis_angle_vector_rotate_top.sv
// channel | dir | tdata fields, low bit up
// s_axis  | in  | vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
// m_axis  | out | rot_x, rot_y, rot_z
// One item per cycle sustained while the output is not stalled; pipeline stages in order:
// input stage, CORDIC stages, sin/cos clamp, three term stages, three product stages.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
`default_nettype none
module axis_angle_vector_rotate_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  wire logic [aavr_pkg::IN_W-1:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // rot_x, rot_y, rot_z
  output logic [aavr_pkg::OUT_W-1:0] m_tdata
);

  localparam int VW = aavr_pkg::VEC_WIDTH;
  localparam int AXW = aavr_pkg::AXIS_WIDTH;
  localparam int AB = 3 * VW;
  localparam int GB = AB + 3 * AXW;

  logic en;
  aavr_pkg::item_t in_item;
  logic cv, tv;
  aavr_pkg::item_t c_item;
  aavr_pkg::sc_t c_sc;
  aavr_pkg::vec_t t_vec;
  aavr_pkg::mat_t t_mat;
  aavr_pkg::vec_t rot;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_item.vec.x = s_tdata[VW-1:0];
  assign in_item.vec.y = s_tdata[2*VW-1:VW];
  assign in_item.vec.z = s_tdata[3*VW-1:2*VW];
  assign in_item.axis.x = s_tdata[AB+AXW-1:AB];
  assign in_item.axis.y = s_tdata[AB+2*AXW-1:AB+AXW];
  assign in_item.axis.z = s_tdata[AB+3*AXW-1:AB+2*AXW];

  aavr_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_item(in_item),
    .in_angle(s_tdata[GB+aavr_pkg::ANGLE_WIDTH-1:GB]),
    .out_valid(cv), .out_item(c_item), .out_sc(c_sc)
  );

  aavr_terms u_terms (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv), .in_item(c_item), .in_sc(c_sc),
    .out_valid(tv), .out_vec(t_vec), .out_mat(t_mat)
  );

  aavr_apply u_apply (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(tv), .in_vec(t_vec), .in_mat(t_mat),
    .out_valid(m_tvalid), .out_vec(rot)
  );

  assign m_tdata = aavr_pkg::OUT_W'({rot.z, rot.y, rot.x});

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output stall");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } rot_vec_t;

  class rotation_scoreboard;
    rot_vec_t expected_rots[$];
    int errors;
    int checked;
    longint atan_tbl[24];

    function new();
      atan_tbl = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      errors = 0;
      checked = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void cos_sin(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] ph;
      logic flip;
      longint x, y, z, dx, dy;
      int n;
      ph = {ang, 16'h0000};
      flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
      if (flip) ph = ph + 32'h80000000;
      z = longint'($signed(ph));
      x = 64'h26DD3B6A;
      y = 0;
      n = aavr_pkg::CORDIC_STAGES > 24 ? 24 : aavr_pkg::CORDIC_STAGES;
      for (int i = 0; i < n; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tbl[i];
        end else begin
          x += dx; y -= dy; z += atan_tbl[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
      s = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
    endfunction

    function longint mat_term(longint ai, longint aj, longint t, longint extra);
      return clip(((ai * aj * t) >>> 31) + extra, -(64'sd1 << 29), 64'sd1 << 29);
    endfunction

    function longint row_dot(longint m0, longint m1, longint m2, longint v[3]);
      longint m[3];
      longint hi, lo, r;
      m = '{m0, m1, m2};
      hi = 0;
      lo = 0;
      for (int j = 0; j < 3; j++) begin
        hi += m[j] * (v[j] >>> 16);
        lo += m[j] * (v[j] & 64'hFFFF);
      end
      r = (hi + (lo >>> 16)) >>> 11;
      return clip(r, -(64'sd1 << 31), (64'sd1 << 31) - 1);
    endfunction

    function void note_item(logic [aavr_pkg::IN_W-1:0] d);
      longint v[3];
      longint a[3];
      longint c, s, t, c27;
      longint w[3];
      rot_vec_t e;
      for (int k = 0; k < 3; k++) begin
        v[k] = longint'($signed(d[32*k +: 32]));
        a[k] = longint'($signed(d[96 + 16*k +: 16]));
      end
      cos_sin(d[144 +: 16], c, s);
      t = (64'sd1 << 30) - c;
      c27 = c >>> 3;
      for (int k = 0; k < 3; k++) w[k] = (a[k] * s) >>> 17;
      e.x = row_dot(mat_term(a[0], a[0], t, c27), mat_term(a[0], a[1], t, -w[2]),
                    mat_term(a[0], a[2], t, w[1]), v);
      e.y = row_dot(mat_term(a[1], a[0], t, w[2]), mat_term(a[1], a[1], t, c27),
                    mat_term(a[1], a[2], t, -w[0]), v);
      e.z = row_dot(mat_term(a[2], a[0], t, -w[1]), mat_term(a[2], a[1], t, w[0]),
                    mat_term(a[2], a[2], t, c27), v);
      expected_rots.push_back(e);
    endfunction

    function void check_result(logic [aavr_pkg::OUT_W-1:0] r);
      rot_vec_t e;
      longint got[3];
      longint exp_v[3];
      string names[3];
      names = '{"rot_x", "rot_y", "rot_z"};
      if (expected_rots.size() == 0) begin
        $error("unexpected result %h", r);
        errors++;
        return;
      end
      e = expected_rots.pop_front();
      exp_v = '{e.x, e.y, e.z};
      for (int k = 0; k < 3; k++) begin
        got[k] = longint'($signed(r[32*k +: 32]));
        if (got[k] != exp_v[k]) begin
          $error("%s mismatch: expected %0d, got %0d", names[k], exp_v[k], got[k]);
          errors++;
        end
      end
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [aavr_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [aavr_pkg::OUT_W-1:0] m_tdata;

  rotation_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int sent = 0;

  always #6 clk = ~clk;

  axis_angle_vector_rotate_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 300;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_item(input logic [aavr_pkg::IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_item(d);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [aavr_pkg::IN_W-1:0] pack_item(logic [31:0] vx, logic [31:0] vy,
      logic [31:0] vz, logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [15:0] ang);
    return {ang, az, ay, ax, vz, vy, vx};
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  function automatic logic [aavr_pkg::IN_W-1:0] rand_item();
    real rx, ry, rz, len;
    logic [15:0] ax, ay, az;
    if ($urandom_range(9) < 8) begin
      do begin
        rx = $itor($signed($urandom_range(2000)) - 1000);
        ry = $itor($signed($urandom_range(2000)) - 1000);
        rz = $itor($signed($urandom_range(2000)) - 1000);
        len = $sqrt(rx * rx + ry * ry + rz * rz);
      end while (len < 1.0);
      ax = 16'($rtoi(rx / len * 16384.0));
      ay = 16'($rtoi(ry / len * 16384.0));
      az = 16'($rtoi(rz / len * 16384.0));
    end else begin
      ax = 16'($signed($urandom_range(32768)) - 16384);
      ay = 16'($signed($urandom_range(32768)) - 16384);
      az = 16'($signed($urandom_range(32768)) - 16384);
    end
    return pack_item(rand_comp(), rand_comp(), rand_comp(), ax, ay, az, 16'($urandom()));
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_rots.size() != 0) @(negedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [15:0] dir_angles[6];
    dir_angles = '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000, 16'h2000};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(pack_item(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h1234));
    foreach (dir_angles[i])
      send_item(pack_item(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 16'h0, 16'h0, 16'h4000,
                          dir_angles[i]));
    send_item(pack_item(32'h00010000, 32'h00020000, 32'h00030000, 16'hC000, 16'h0, 16'h0,
                        16'h4000));
    send_item(pack_item(32'h00010000, 32'h00020000, 32'h00030000, 16'h0, 16'h4000, 16'h0,
                        16'h4000));
    send_item(pack_item(32'h00010000, 32'h00020000, 32'h00030000, 16'h0, 16'hC000, 16'h0,
                        16'hE000));
    send_item(pack_item(32'h00010000, 32'h00020000, 32'h00030000, 16'h0, 16'h0, 16'hC000,
                        16'h6000));
    send_item(pack_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000, 16'h4000, 16'h4000,
                        16'h1000));
    send_item(pack_item(32'h80000000, 32'h80000000, 32'h80000000, 16'h4000, 16'h4000, 16'h4000,
                        16'h9000));
    send_item(pack_item(32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0000, 16'h8000, 16'h8000,
                        16'h8000, 16'h5555));
    send_item(pack_item(32'h12345678, 32'hDEADBEEF, 32'h00000001, 16'h8000, 16'h0, 16'h0,
                        16'hFFFF));
    send_item(pack_item(32'h40000000, 32'hC0000000, 32'h00000000, 16'h2D41, 16'h2D41, 16'h0,
                        16'h8001));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph == 2) begin
        send_idle_pct = 0;
        hold_requests++;
        repeat (60) send_item(rand_item());
        send_idle_pct = 0;
      end
      repeat (280) begin
        send_item(rand_item());
        if ($urandom_range(99) < 2) begin
          recv_stall_pct = 0;
          repeat ($urandom_range(40, 5)) send_item(rand_item());
          recv_stall_pct = (ph == 2) ? 65 : (ph == 3 ? 26 : 0);
        end
      end
      drain();
    end

    repeat (40) @(negedge clk);
    $display("Covered %0d items: directed extremes, all quadrants, saturation, -2.0 axes,", sent);
    $display("random unit and raw axes under idle, stall, backpressure hold; %0d checked",
             sb.checked);
    if (sb.errors == 0 && sb.expected_rots.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/aavr_pkg.sv
sv/aavr_cordic.sv
sv/aavr_terms.sv
sv/aavr_apply.sv
sv/axis_angle_vector_rotate_top.sv
verif/tb_top.sv
